FILE: design/pi_rate_feedback_controller_macros.svh
// ---------------------------------------------------------------------------
// PI rate feedback controller assertion macros
// Shorthand for the concurrent checks in the port checker.
// ---------------------------------------------------------------------------
`ifndef PI_RATE_FEEDBACK_CONTROLLER_MACROS_SVH
`define PI_RATE_FEEDBACK_CONTROLLER_MACROS_SVH

// check on every clock edge outside reset
`define PIRFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define PIRFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/pirfc_pkg.sv
// ---------------------------------------------------------------------------
// PI rate feedback controller package
// Widths, reset values, register indexes, states and interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package pirfc_pkg;

  localparam int SampleW   = 12;
  localparam int SetpointW = 12;
  localparam int GainW     = 16;
  localparam int DutyW     = 16;
  localparam int IntegW    = 48;
  localparam int FracW     = 16;
  localparam int KpFracW   = 8;
  localparam int KdFracW   = 4;

  localparam int ErrW      = ((SampleW > SetpointW) ? SampleW : SetpointW) + 1;
  localparam int McW       = IntegW + 1;
  localparam int ProdW     = McW + GainW;
  localparam int RateW     = ErrW + GainW;
  localparam int RateShift = FracW - KdFracW;
  localparam int PropW     = ProdW - KpFracW;
  localparam int UW        = PropW + 1;

  localparam int MulSteps  = GainW;
  localparam int MulCntW   = $clog2(MulSteps);

  // accept edge to first edge at which the result shows valid
  localparam int LatencyCycles = 3 * (MulSteps + 1) + 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [SetpointW-1:0] SetpointRst = SetpointW'(2048);
  localparam logic [GainW-1:0]     KpRst       = GainW'(1920);
  localparam logic [GainW-1:0]     KiRst       = GainW'(420);
  localparam logic [GainW-1:0]     KdRst       = GainW'(12160);
  localparam logic [DutyW-1:0]     DutyMaxRst  = DutyW'(99);

  localparam logic [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    RegSetpoint = 3'd0,
    RegKp       = 3'd1,
    RegKi       = 3'd2,
    RegKd       = 3'd3,
    RegDutyMax  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMulI,
    StMulD,
    StMulP,
    StDrive
  } state_e;

  typedef struct packed {
    logic               start;
    logic [McW-1:0]     mcand;
    logic [GainW-1:0]   mplier;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic [ProdW-1:0]   product;
  } mul_rsp_t;

endpackage

`default_nettype wire

FILE: design/pirfc_serial_mul.sv
// ---------------------------------------------------------------------------
// Serial shift-add multiplier
// Signed multiplicand times unsigned gain, one gain bit per cycle, LSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module pirfc_serial_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pirfc_pkg::mul_req_t req_i,
  output pirfc_pkg::mul_rsp_t      rsp_o
);

  logic                              busy_q, busy_d;
  logic [pirfc_pkg::MulCntW-1:0]     cnt_q, cnt_d;
  logic [pirfc_pkg::McW-1:0]         mcand_q, mcand_d;
  logic [pirfc_pkg::McW-1:0]         hi_q, hi_d;
  logic [pirfc_pkg::GainW-1:0]       lo_q, lo_d;
  logic [pirfc_pkg::McW:0]           sum;

  always_comb begin
    sum = {hi_q[pirfc_pkg::McW-1], hi_q}
        + (lo_q[0] ? {mcand_q[pirfc_pkg::McW-1], mcand_q} : '0);
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = pirfc_pkg::MulCntW'(pirfc_pkg::MulSteps - 1);
      mcand_d = req_i.mcand;
      hi_d    = '0;
      lo_d    = req_i.mplier;
    end else if (busy_q) begin
      // add partial product, then shift the whole product right by one
      hi_d = sum[pirfc_pkg::McW:1];
      lo_d = {sum[0], lo_q[pirfc_pkg::GainW-1:1]};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - pirfc_pkg::MulCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.product = {hi_q, lo_q};

endmodule

`default_nettype wire

FILE: design/pi_rate_feedback_controller.sv
// ---------------------------------------------------------------------------
// PI controller with rate feedback
// Throughput: a new sample is accepted only in the idle state, so one sample is
// in flight at a time; three 16-step products on one bit-serial shift-add
// multiplier, and any output stall, set the pace.
// Reset: config registers return to defaults, integrator and last sample clear.
// ---------------------------------------------------------------------------
`default_nettype none

module pi_rate_feedback_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pirfc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [pirfc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [pirfc_pkg::SampleW-1:0]     sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [pirfc_pkg::DutyW-1:0]            duty_o,
  output logic                                   clamped_o
);

  localparam int ErrPad  = pirfc_pkg::McW - pirfc_pkg::ErrW;
  localparam int SPad    = pirfc_pkg::McW - pirfc_pkg::ErrW - pirfc_pkg::FracW;
  localparam int IPad    = pirfc_pkg::McW - pirfc_pkg::RateW;
  localparam int RatePad = pirfc_pkg::UW - pirfc_pkg::RateW - pirfc_pkg::RateShift;
  localparam int DutyLo  = pirfc_pkg::FracW;
  localparam int DutyHi  = pirfc_pkg::FracW + pirfc_pkg::DutyW;

  pirfc_pkg::state_e state_q, state_d;

  logic [pirfc_pkg::SetpointW-1:0] setpoint_q, setpoint_d;
  logic [pirfc_pkg::GainW-1:0]     kp_q, kp_d;
  logic [pirfc_pkg::GainW-1:0]     ki_q, ki_d;
  logic [pirfc_pkg::GainW-1:0]     kd_q, kd_d;
  logic [pirfc_pkg::DutyW-1:0]     duty_max_q, duty_max_d;

  logic [pirfc_pkg::IntegW-1:0]    integ_q, integ_d;
  logic [pirfc_pkg::SampleW-1:0]   last_sample_q, last_sample_d;
  logic                            out_valid_q, out_valid_d;

  logic [pirfc_pkg::ErrW-1:0]      err_q, err_d;
  logic [pirfc_pkg::ErrW-1:0]      dy_q, dy_d;
  logic [pirfc_pkg::McW-1:0]       s_q, s_d;
  logic [pirfc_pkg::RateW-1:0]     rate_q, rate_d;
  logic [pirfc_pkg::UW-1:0]        u_q, u_d;
  logic [pirfc_pkg::DutyW-1:0]     duty_q, duty_d;
  logic                            clamped_q, clamped_d;

  pirfc_pkg::mul_req_t             mul_req;
  pirfc_pkg::mul_rsp_t             mul_rsp;

  logic                            mul_done;
  logic                            out_free;
  logic [pirfc_pkg::ErrW-1:0]      err_in;
  logic [pirfc_pkg::ErrW-1:0]      dy_in;
  logic [pirfc_pkg::McW-1:0]       integ_sum;
  logic [pirfc_pkg::IntegW-1:0]    integ_sat;
  logic [pirfc_pkg::McW-1:0]       s_sum;
  logic [pirfc_pkg::PropW-1:0]     prop;
  logic [pirfc_pkg::UW-1:0]        u_calc;
  logic                            drive_neg;
  logic                            drive_over;

  pirfc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign mul_done = !mul_rsp.busy;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration decode
  always_comb begin
    setpoint_d = setpoint_q;
    kp_d       = kp_q;
    ki_d       = ki_q;
    kd_d       = kd_q;
    duty_max_d = duty_max_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pirfc_pkg::RegSetpoint: setpoint_d = cfg_wdata_i[pirfc_pkg::SetpointW-1:0];
        pirfc_pkg::RegKp:       kp_d       = cfg_wdata_i[pirfc_pkg::GainW-1:0];
        pirfc_pkg::RegKi:       ki_d       = cfg_wdata_i[pirfc_pkg::GainW-1:0];
        pirfc_pkg::RegKd:       kd_d       = cfg_wdata_i[pirfc_pkg::GainW-1:0];
        pirfc_pkg::RegDutyMax:  duty_max_d = cfg_wdata_i[pirfc_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pirfc_pkg::StIdle:  if (in_valid_i) state_d = pirfc_pkg::StMulI;
      pirfc_pkg::StMulI:  if (mul_done)   state_d = pirfc_pkg::StMulD;
      pirfc_pkg::StMulD:  if (mul_done)   state_d = pirfc_pkg::StMulP;
      pirfc_pkg::StMulP:  if (mul_done)   state_d = pirfc_pkg::StDrive;
      pirfc_pkg::StDrive: if (out_free)   state_d = pirfc_pkg::StIdle;
      default:                            state_d = pirfc_pkg::StIdle;
    endcase
  end

  // multiplier requests: error * ki, then delta * kd, then sum * kp
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      pirfc_pkg::StIdle: begin
        if (in_valid_i) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = {{ErrPad{err_in[pirfc_pkg::ErrW-1]}}, err_in};
          mul_req.mplier = ki_q;
        end
      end
      pirfc_pkg::StMulI: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = {{ErrPad{dy_q[pirfc_pkg::ErrW-1]}}, dy_q};
          mul_req.mplier = kd_q;
        end
      end
      pirfc_pkg::StMulD: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = s_q;
          mul_req.mplier = kp_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != pirfc_pkg::StIdle);

  // datapath
  always_comb begin
    err_in = pirfc_pkg::ErrW'(setpoint_q) - pirfc_pkg::ErrW'(sample_i);
    dy_in  = pirfc_pkg::ErrW'(sample_i) - pirfc_pkg::ErrW'(last_sample_q);

    integ_sum = {integ_q[pirfc_pkg::IntegW-1], integ_q}
              + {{IPad{mul_rsp.product[pirfc_pkg::RateW-1]}},
                 mul_rsp.product[pirfc_pkg::RateW-1:0]};
    // saturate at the integrator width
    if (integ_sum[pirfc_pkg::McW-1] != integ_sum[pirfc_pkg::McW-2]) begin
      integ_sat = integ_sum[pirfc_pkg::McW-1] ? pirfc_pkg::IntegMin : pirfc_pkg::IntegMax;
    end else begin
      integ_sat = integ_sum[pirfc_pkg::IntegW-1:0];
    end

    s_sum = {{SPad{err_q[pirfc_pkg::ErrW-1]}}, err_q, {pirfc_pkg::FracW{1'b0}}}
          + {integ_q[pirfc_pkg::IntegW-1], integ_q};

    // floor of kp * s down to the integrator fraction
    prop   = mul_rsp.product[pirfc_pkg::ProdW-1:pirfc_pkg::KpFracW];
    u_calc = {prop[pirfc_pkg::PropW-1], prop}
           - {{RatePad{rate_q[pirfc_pkg::RateW-1]}}, rate_q, {pirfc_pkg::RateShift{1'b0}}};

    drive_neg  = u_q[pirfc_pkg::UW-1];
    drive_over = (|u_q[pirfc_pkg::UW-2:DutyHi])
               || (u_q[DutyHi-1:DutyLo] > duty_max_q)
               || ((u_q[DutyHi-1:DutyLo] == duty_max_q) && (|u_q[DutyLo-1:0]));

    integ_d       = integ_q;
    last_sample_d = last_sample_q;
    out_valid_d   = out_valid_q;
    err_d         = err_q;
    dy_d          = dy_q;
    s_d           = s_q;
    rate_d        = rate_q;
    u_d           = u_q;
    duty_d        = duty_q;
    clamped_d     = clamped_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pirfc_pkg::StIdle: begin
        if (in_valid_i) begin
          err_d         = err_in;
          dy_d          = dy_in;
          last_sample_d = sample_i;
        end
      end
      pirfc_pkg::StMulI: begin
        if (mul_done) integ_d = integ_sat;
      end
      pirfc_pkg::StMulD: begin
        // integrator is final here, so the sum settles long before it is used
        s_d = s_sum;
        if (mul_done) rate_d = mul_rsp.product[pirfc_pkg::RateW-1:0];
      end
      pirfc_pkg::StMulP: begin
        if (mul_done) u_d = u_calc;
      end
      pirfc_pkg::StDrive: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (drive_neg) begin
            duty_d    = '0;
            clamped_d = 1'b1;
          end else if (drive_over) begin
            duty_d    = duty_max_q;
            clamped_d = 1'b1;
          end else begin
            duty_d    = u_q[DutyHi-1:DutyLo];
            clamped_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pirfc_pkg::StIdle;
      setpoint_q    <= pirfc_pkg::SetpointRst;
      kp_q          <= pirfc_pkg::KpRst;
      ki_q          <= pirfc_pkg::KiRst;
      kd_q          <= pirfc_pkg::KdRst;
      duty_max_q    <= pirfc_pkg::DutyMaxRst;
      integ_q       <= '0;
      last_sample_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      setpoint_q    <= setpoint_d;
      kp_q          <= kp_d;
      ki_q          <= ki_d;
      kd_q          <= kd_d;
      duty_max_q    <= duty_max_d;
      integ_q       <= integ_d;
      last_sample_q <= last_sample_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    dy_q      <= dy_d;
    s_q       <= s_d;
    rate_q    <= rate_d;
    u_q       <= u_d;
    duty_q    <= duty_d;
    clamped_q <= clamped_d;
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign clamped_o   = clamped_q;

endmodule

`default_nettype wire

FILE: design/pirfc_checker.sv
// ---------------------------------------------------------------------------
// PI rate feedback controller port checker
// Watches the request channels of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pi_rate_feedback_controller_macros.svh"

module pirfc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [pirfc_pkg::DutyW-1:0]   duty_o,
  input wire logic                          clamped_o
);

  // the first reset edge clears the result flag, so look one edge later
  `PIRFC_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

  `PIRFC_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "second request taken while an item is in flight")

  `PIRFC_ASSERT(a_result_holds, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(duty_o) && $stable(clamped_o)), "stalled result changed")

  `PIRFC_ASSERT(a_result_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, pirfc_pkg::LatencyCycles), "result not at fixed latency after request")

endmodule

bind pi_rate_feedback_controller pirfc_checker u_pirfc_checker (.*);

`default_nettype wire

FILE: tb/pi_rate_feedback_controller_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// PI rate feedback controller testbench
// Drives plant samples through the valid/stall request channel under random
// idling and back-pressure. A bit-true predictor tracks the integrator and the
// previous sample and checks every duty result, across several gain settings.
// ---------------------------------------------------------------------------

module pi_rate_feedback_controller_tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldAfter    = 300;
  localparam int unsigned RandPhases   = 9;
  localparam int unsigned PhaseSamples = 160;
  localparam int          SampleMax    = (1 << pirfc_pkg::SampleW) - 1;

  // indexes that decode to no register
  localparam logic [pirfc_pkg::CfgIdxW-1:0] RegNone0 = 3'd5;
  localparam logic [pirfc_pkg::CfgIdxW-1:0] RegNone1 = 3'd6;
  localparam logic [pirfc_pkg::CfgIdxW-1:0] RegNone2 = 3'd7;

  typedef struct packed {
    logic [pirfc_pkg::DutyW-1:0] duty;
    logic                        clamped;
  } duty_expect_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [pirfc_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [pirfc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [pirfc_pkg::SampleW-1:0]  sample_i    = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [pirfc_pkg::DutyW-1:0]    duty_o;
  logic                           clamped_o;

  // controller state and registers as the predictor sees them
  logic [pirfc_pkg::SetpointW-1:0]     setpoint_r  = pirfc_pkg::SetpointRst;
  logic [pirfc_pkg::GainW-1:0]         kp_r        = pirfc_pkg::KpRst;
  logic [pirfc_pkg::GainW-1:0]         ki_r        = pirfc_pkg::KiRst;
  logic [pirfc_pkg::GainW-1:0]         kd_r        = pirfc_pkg::KdRst;
  logic [pirfc_pkg::DutyW-1:0]         duty_max_r  = pirfc_pkg::DutyMaxRst;
  logic signed [pirfc_pkg::IntegW-1:0] integ_acc   = '0;
  logic [pirfc_pkg::SampleW-1:0]       prev_sample = '0;

  logic [pirfc_pkg::SampleW-1:0] sample_backlog[$];
  duty_expect_t                  duty_expect_q[$];
  duty_expect_t                  head;

  int unsigned idle_pct         = 32;
  int unsigned samples_accepted = 0;
  int unsigned hold_left        = 0;
  bit          hold_done        = 1'b0;
  int unsigned cycle_count      = 0;
  int unsigned fail_count       = 0;
  int unsigned results_checked  = 0;
  int unsigned clamp_seen       = 0;
  int unsigned settings_run     = 0;

  pi_rate_feedback_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .duty_o      (duty_o),
    .clamped_o   (clamped_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // advance the controller by one sample and queue the duty it must produce
  function automatic void compute_duty(input logic [pirfc_pkg::SampleW-1:0] y);
    logic signed [127:0] sp_w, y_w, last_w, kp_w, ki_w, kd_w, lim_w;
    logic signed [127:0] err, acc, prop, rate, u, hi_w, lo_w;
    duty_expect_t res;
    sp_w   = setpoint_r;
    y_w    = y;
    last_w = prev_sample;
    kp_w   = kp_r;
    ki_w   = ki_r;
    kd_w   = kd_r;
    lim_w  = duty_max_r;
    lim_w  = lim_w <<< pirfc_pkg::FracW;
    hi_w   = pirfc_pkg::IntegMax;
    lo_w   = $signed(pirfc_pkg::IntegMin);
    err = sp_w - y_w;
    acc = integ_acc;
    acc = acc + err * ki_w;
    if (acc > hi_w) acc = hi_w;
    if (acc < lo_w) acc = lo_w;
    integ_acc = acc[pirfc_pkg::IntegW-1:0];
    prop = (kp_w * ((err <<< pirfc_pkg::FracW) + acc)) >>> pirfc_pkg::KpFracW;
    rate = (kd_w * (y_w - last_w)) <<< (pirfc_pkg::FracW - pirfc_pkg::KdFracW);
    prev_sample = y;
    u = prop - rate;
    if (u < 0) begin
      res.duty    = '0;
      res.clamped = 1'b1;
    end else if (u > lim_w) begin
      res.duty    = duty_max_r;
      res.clamped = 1'b1;
    end else begin
      res.duty    = u[pirfc_pkg::FracW +: pirfc_pkg::DutyW];
      res.clamped = 1'b0;
    end
    duty_expect_q.push_back(res);
  endfunction

  function automatic logic [pirfc_pkg::SampleW-1:0] next_sample(input int prev);
    int v;
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      v = int'(setpoint_r) + $urandom_range(96) - 48;
    end else if (r < 75) begin
      v = prev + $urandom_range(16) - 8;
    end else if (r < 92) begin
      v = $urandom_range(SampleMax);
    end else begin
      v = $urandom_range(1) ? SampleMax : 0;
    end
    if (v < 0) v = 0;
    if (v > SampleMax) v = SampleMax;
    return v[pirfc_pkg::SampleW-1:0];
  endfunction

  function automatic logic [pirfc_pkg::GainW-1:0] pick_gain(input int unsigned lo,
                                                            input int unsigned hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return pirfc_pkg::GainW'($urandom_range(65535));
    return pirfc_pkg::GainW'($urandom_range(hi, lo));
  endfunction

  task automatic write_reg(input logic [pirfc_pkg::CfgIdxW-1:0] idx,
                           input logic [pirfc_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pirfc_pkg::RegSetpoint: setpoint_r = data[pirfc_pkg::SetpointW-1:0];
      pirfc_pkg::RegKp:       kp_r       = data;
      pirfc_pkg::RegKi:       ki_r       = data;
      pirfc_pkg::RegKd:       kd_r       = data;
      pirfc_pkg::RegDutyMax:  duty_max_r = data;
      default: ;
    endcase
  endtask

  // wait until every queued request has been answered, then count the setting
  task automatic drain_results();
    while (sample_backlog.size() != 0 || in_valid_i || duty_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    settings_run++;
    @(negedge clk_i);
  endtask

  task automatic queue_samples(input logic [pirfc_pkg::SampleW-1:0] vals[$]);
    foreach (vals[k]) sample_backlog.push_back(vals[k]);
  endtask

  // sample request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        compute_duty(sample_i);
        samples_accepted <= samples_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= sample_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off once traffic is under way
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && samples_accepted >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // duty result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (duty_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] duty result with none pending: duty=%0d clamped=%0b",
                     $time, duty_o, clamped_o);
          end
        end else begin
          head = duty_expect_q.pop_front();
          results_checked++;
          if (clamped_o) clamp_seen++;
          if (duty_o !== head.duty || clamped_o !== head.clamped) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] duty mismatch: expected duty=%0d clamped=%0b, got duty=%0d clamped=%0b",
                       $time, head.duty, head.clamped, duty_o, clamped_o);
            end
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int prev;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset gains: error extremes, zero error, large rate steps
    queue_samples('{12'd2048, 12'd2048, 12'd2047, 12'd2049, 12'd2050, 12'd2040,
                    12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2100, 12'd2000});
    drain_results();

    // rate term only: drive equal to the limit, above it, zero, and negative
    write_reg(pirfc_pkg::RegKi, '0);
    write_reg(pirfc_pkg::RegKp, '0);
    write_reg(pirfc_pkg::RegKd, 16'd16);
    write_reg(pirfc_pkg::RegDutyMax, 16'd100);
    @(negedge clk_i);
    queue_samples('{12'd2000, 12'd1900, 12'd1799, 12'd1799, 12'd1850});
    drain_results();

    // fractional drive truncates; writes to unmapped indexes must not land
    write_reg(pirfc_pkg::RegKd, 16'd17);
    write_reg(pirfc_pkg::RegDutyMax, 16'hFFFF);
    write_reg(RegNone0, 16'hFFFF);
    write_reg(RegNone1, 16'hFFFF);
    write_reg(RegNone2, 16'hFFFF);
    @(negedge clk_i);
    queue_samples('{12'd1840});
    drain_results();
    write_reg(pirfc_pkg::RegKd, 16'd1);
    @(negedge clk_i);
    queue_samples('{12'd1835});
    drain_results();

    // all gains at full scale, zero duty ceiling, setpoint upper bits dropped
    write_reg(pirfc_pkg::RegSetpoint, 16'hFFFF);
    write_reg(pirfc_pkg::RegKp, 16'hFFFF);
    write_reg(pirfc_pkg::RegKi, 16'hFFFF);
    write_reg(pirfc_pkg::RegKd, 16'hFFFF);
    write_reg(pirfc_pkg::RegDutyMax, '0);
    @(negedge clk_i);
    queue_samples('{12'd0, 12'd4095, 12'd0, 12'd4095});
    drain_results();

    for (int p = 0; p < RandPhases; p++) begin
      write_reg(pirfc_pkg::RegSetpoint,
                ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) :
                                           16'($urandom_range(3800, 300)));
      write_reg(pirfc_pkg::RegKp, pick_gain(64, 1024));
      write_reg(pirfc_pkg::RegKi, pick_gain(0, 400));
      write_reg(pirfc_pkg::RegKd, pick_gain(0, 48));
      write_reg(pirfc_pkg::RegDutyMax, pick_gain(64, 4000));
      @(negedge clk_i);
      idle_pct = (p == 3) ? 0 : 32;
      prev = setpoint_r;
      for (int k = 0; k < PhaseSamples; k++) begin
        sample_backlog.push_back(next_sample(prev));
        prev = sample_backlog[$];
      end
      drain_results();
    end

    repeat (2 * pirfc_pkg::LatencyCycles) @(posedge clk_i);
    if (duty_expect_q.size() != 0) begin
      fail_count += duty_expect_q.size();
      $display("%0d duty results never arrived", duty_expect_q.size());
    end
    $display("Checked %0d duty results from %0d samples over %0d register settings,",
             results_checked, samples_accepted, settings_run);
    $display("%0d of them clamped; %0d failures.", clamp_seen, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
